// File: sv/drti16_pkg.sv
// shared types, constants and table functions for the decimal rescale block
// no dependencies; imported by every module of the block
`default_nettype none

package drti16_pkg;

	localparam int LANES = 3;
	localparam int STEPS = 5;

	localparam int VAL_W = 32;
	localparam int RES_W = 16;
	localparam int SCL_W = 8;
	localparam int EXP_W = 3;
	localparam int CNT_W = 2;
	// reduced dividend after the 2^k shift, and the reciprocal multiplier
	localparam int RED_W = 31;
	localparam int MUL_W = 32;
	localparam int PRD_W = RED_W + MUL_W;
	localparam int SHF_W = 6;

	typedef logic [EXP_W-1:0] expo_t;

	// per-lane magnitude and sign handed to the merge stage
	typedef struct packed {
		logic [VAL_W-1:0] mag;
		logic             neg;
	} lane_info_t;

	localparam expo_t EXP_NONE = 3'd0;
	localparam expo_t EXP_E1   = 3'd1;
	localparam expo_t EXP_E2   = 3'd2;
	localparam expo_t EXP_E3   = 3'd3;
	localparam expo_t EXP_E4   = 3'd4;
	localparam expo_t EXP_E5   = 3'd5;

	// thresholds: above THR_x[j] the value needs 10^(5-j)
	localparam logic [VAL_W-1:0] THR_POS [STEPS] = '{
		32'd327674999, 32'd32767499, 32'd3276749, 32'd327674, 32'd32767
	};
	localparam logic [VAL_W-1:0] THR_NEG [STEPS] = '{
		32'd327684999, 32'd32768499, 32'd3276849, 32'd327684, 32'd32768
	};

	// half of 10^k, for round half away from zero
	function automatic logic [VAL_W-1:0] half_of(input expo_t k);
		logic [VAL_W-1:0] h;
		unique case (k)
			EXP_E1:  h = 32'd5;
			EXP_E2:  h = 32'd50;
			EXP_E3:  h = 32'd500;
			EXP_E4:  h = 32'd5000;
			EXP_E5:  h = 32'd50000;
			default: h = 32'd0;
		endcase
		return h;
	endfunction

	// ceil(2^s / 5^k), exact for a 31-bit dividend
	function automatic logic [MUL_W-1:0] magic_of(input expo_t k);
		logic [MUL_W-1:0] m;
		unique case (k)
			EXP_E1:  m = 32'd3435973837;
			EXP_E2:  m = 32'd2748779070;
			EXP_E3:  m = 32'd2199023256;
			EXP_E4:  m = 32'd3518437209;
			EXP_E5:  m = 32'd2814749768;
			default: m = 32'd0;
		endcase
		return m;
	endfunction

	function automatic logic [SHF_W-1:0] shift_of(input expo_t k);
		logic [SHF_W-1:0] s;
		unique case (k)
			EXP_E1:  s = 6'd34;
			EXP_E2:  s = 6'd36;
			EXP_E3:  s = 6'd38;
			EXP_E4:  s = 6'd41;
			EXP_E5:  s = 6'd43;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// File: sv/drti16_lane.sv
// one lane: magnitude, rounding offset, divide by 10^k through a shift and a
// reciprocal multiply, sign restore; uses drti16_pkg
`default_nettype none

module drti16_lane import drti16_pkg::*; (
	input  wire logic             clk,
	input  wire logic [VAL_W-1:0] raw_s1,
	input  wire logic             active_s1,
	output lane_info_t            info_s2,
	input  wire expo_t            k_s4,
	output logic      [RES_W-1:0] res_s7
);

	logic [VAL_W-1:0] abs_s1;
	logic [VAL_W-1:0] mag_s2, mag_s3, mag_s4;
	logic             neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [VAL_W:0]   x_s4;
	logic [RED_W-1:0] y_s5;
	logic [RES_W-1:0] byp_s5, byp_s6;
	expo_t            k_s5, k_s6;
	logic [PRD_W-1:0] prod_s6;
	logic [RES_W-1:0] q_s6;

	assign abs_s1 = raw_s1[VAL_W-1] ? (VAL_W'(0) - raw_s1) : raw_s1;

	always_ff @(posedge clk) begin
		mag_s2 <= active_s1 ? abs_s1 : '0;
		neg_s2 <= active_s1 & raw_s1[VAL_W-1];
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;
	end

	assign info_s2.mag = mag_s2;
	assign info_s2.neg = neg_s2;

	// 10^k = 2^k * 5^k: shift first, then a 31-bit dividend for the multiply
	assign x_s4 = {1'b0, mag_s4} + {1'b0, half_of(k_s4)};

	always_ff @(posedge clk) begin
		y_s5    <= RED_W'(x_s4 >> k_s4);
		byp_s5  <= mag_s4[RES_W-1:0];
		neg_s5  <= neg_s4;
		k_s5    <= k_s4;
		prod_s6 <= PRD_W'(y_s5) * PRD_W'(magic_of(k_s5));
		byp_s6  <= byp_s5;
		neg_s6  <= neg_s5;
		k_s6    <= k_s5;
	end

	assign q_s6 = (k_s6 == EXP_NONE) ? byp_s6 : RES_W'(prod_s6 >> shift_of(k_s6));

	always_ff @(posedge clk) begin
		res_s7 <= neg_s6 ? (RES_W'(0) - q_s6) : q_s6;
	end

endmodule

`default_nettype wire

// File: sv/drti16_merge.sv
// merge stage: largest magnitude over the lanes, sign rule, threshold search
// giving the power of ten; uses drti16_pkg
`default_nettype none

module drti16_merge import drti16_pkg::*; (
	input  wire logic       clk,
	input  wire logic       exact_neg,
	input  wire lane_info_t info_s2 [LANES],
	output expo_t           k_s4
);

	logic [VAL_W-1:0] max_c;
	logic             pos_c;
	logic [VAL_W-1:0] max_s3;
	logic             pos_s3;
	logic             use_neg;
	logic [VAL_W-1:0] thr [STEPS];
	expo_t            k_c;

	always_comb begin
		max_c = '0;
		for (int i = 0; i < LANES; i++) begin
			if (info_s2[i].mag > max_c) begin
				max_c = info_s2[i].mag;
			end
		end
		// a positive lane at the maximum selects the positive table
		pos_c = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			if (!info_s2[i].neg && info_s2[i].mag == max_c) begin
				pos_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		max_s3 <= max_c;
		pos_s3 <= pos_c;
	end

	assign use_neg = exact_neg & ~pos_s3;

	always_comb begin
		for (int j = 0; j < STEPS; j++) begin
			thr[j] = use_neg ? THR_NEG[j] : THR_POS[j];
		end
		priority if (max_s3 > thr[0]) begin
			k_c = EXP_E5;
		end else if (max_s3 > thr[1]) begin
			k_c = EXP_E4;
		end else if (max_s3 > thr[2]) begin
			k_c = EXP_E3;
		end else if (max_s3 > thr[3]) begin
			k_c = EXP_E2;
		end else if (max_s3 > thr[4]) begin
			k_c = EXP_E1;
		end else begin
			k_c = EXP_NONE;
		end
	end

	always_ff @(posedge clk) begin
		k_s4 <= k_c;
	end

endmodule

`default_nettype wire

// File: sv/decimal_rescale_to_int16_core.sv
// top level of the decimal rescale block: input and output registers, scale
// path, lanes and merge; uses drti16_pkg, drti16_lane, drti16_merge
//
// usage
//   a beat is taken on start while busy is low; busy is always low, so a new
//   record may be issued every cycle. value_0..2 are signed samples,
//   lane_count selects how many lanes from lane 0 take part, scale_in is the
//   record's decimal exponent.
//   results appear from the output register, held for one cycle with
//   done high; the receiver cannot stall and none is needed, the pipeline
//   runs freely at one record per cycle.
//   latency is set by the stages: input, magnitude, maximum, threshold search,
//   rounding shift, reciprocal multiply, and sign restore into the output
//   register.
//   the configuration channel (cfg_valid/cfg_ready/cfg_data) writes the
//   exact negative range bit; cfg_ready is always high and the bit should
//   only change while no record is in flight.
//   reset clears the valid pipeline and the configuration bit to 0; no
//   clearing pass is needed.
`default_nettype none

module decimal_rescale_to_int16_core import drti16_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic signed [VAL_W-1:0] value_0,
	input  wire logic signed [VAL_W-1:0] value_1,
	input  wire logic signed [VAL_W-1:0] value_2,
	input  wire logic        [CNT_W-1:0] lane_count,
	input  wire logic signed [SCL_W-1:0] scale_in,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic                    cfg_data,
	output logic                         done,
	output logic signed      [RES_W-1:0] result_0,
	output logic signed      [RES_W-1:0] result_1,
	output logic signed      [RES_W-1:0] result_2,
	output logic signed      [SCL_W-1:0] scale_out,
	output logic             [EXP_W-1:0] exponent_added
);

	logic             exact_q;
	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [VAL_W-1:0] raw_s1 [LANES];
	logic [CNT_W-1:0] cnt_s1;
	logic [SCL_W-1:0] scl_s1, scl_s2, scl_s3, scl_s4;
	logic [SCL_W-1:0] scl_s5, scl_s6, scl_s7;
	expo_t            k_s4, k_s5, k_s6, k_s7;
	logic [LANES-1:0] active_s1;
	lane_info_t       info_s2 [LANES];
	logic [RES_W-1:0] res_s7 [LANES];
	logic             accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exact_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			exact_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1[0] <= value_0;
			raw_s1[1] <= value_1;
			raw_s1[2] <= value_2;
			cnt_s1    <= lane_count;
			scl_s1    <= scale_in;
		end
	end

	// scale travels alongside the lanes and picks up the exponent at stage 4
	always_ff @(posedge clk) begin
		scl_s2 <= scl_s1;
		scl_s3 <= scl_s2;
		scl_s4 <= scl_s3;
		scl_s5 <= scl_s4 + SCL_W'(k_s4);
		k_s5   <= k_s4;
		scl_s6 <= scl_s5;
		k_s6   <= k_s5;
		scl_s7 <= scl_s6;
		k_s7   <= k_s6;
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		// lanes past the count stay inactive; a count above LANES saturates
		assign active_s1[i] = (32'(cnt_s1) > 32'(i));

		drti16_lane u_lane (
			.clk       (clk),
			.raw_s1    (raw_s1[i]),
			.active_s1 (active_s1[i]),
			.info_s2   (info_s2[i]),
			.k_s4      (k_s4),
			.res_s7    (res_s7[i])
		);
	end

	drti16_merge u_merge (
		.clk       (clk),
		.exact_neg (exact_q),
		.info_s2   (info_s2),
		.k_s4      (k_s4)
	);

	assign done           = v_s7;
	assign result_0       = res_s7[0];
	assign result_1       = res_s7[1];
	assign result_2       = res_s7[2];
	assign scale_out      = scl_s7;
	assign exponent_added = k_s7;

endmodule

`default_nettype wire

// File: verif/decimal_rescale_to_int16_core_tb.sv
// self-checking testbench for decimal_rescale_to_int16_core: directed and random records
// checked against a local predictor of the rescale; depends on drti16_pkg and the core
`default_nettype none

module decimal_rescale_to_int16_core_tb;
	import drti16_pkg::*;

	typedef struct {
		logic signed [VAL_W-1:0] v0;
		logic signed [VAL_W-1:0] v1;
		logic signed [VAL_W-1:0] v2;
		logic        [CNT_W-1:0] cnt;
		logic signed [SCL_W-1:0] scl;
	} record_t;

	typedef struct packed {
		logic signed [RES_W-1:0] res0;
		logic signed [RES_W-1:0] res1;
		logic signed [RES_W-1:0] res2;
		logic signed [SCL_W-1:0] scl;
		expo_t                   ex;
	} rescale_t;

	// packed tables, element 0 is the rightmost entry: index j needs 10^(5-j)
	localparam logic [STEPS-1:0][VAL_W-1:0] POS_LIMIT =
		{32'd32767, 32'd327674, 32'd3276749, 32'd32767499, 32'd327674999};
	localparam logic [STEPS-1:0][VAL_W-1:0] NEG_LIMIT =
		{32'd32768, 32'd327684, 32'd3276849, 32'd32768499, 32'd327684999};
	localparam logic [STEPS-1:0][VAL_W-1:0] DIVISOR =
		{32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000};

	localparam int TAIL_CYCLES = 12;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic signed [VAL_W-1:0] value_0 = '0;
	logic signed [VAL_W-1:0] value_1 = '0;
	logic signed [VAL_W-1:0] value_2 = '0;
	logic        [CNT_W-1:0] lane_count = '0;
	logic signed [SCL_W-1:0] scale_in = '0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_data = 1'b0;
	logic                    busy;
	logic                    cfg_ready;
	logic                    done;
	logic signed [RES_W-1:0] result_0;
	logic signed [RES_W-1:0] result_1;
	logic signed [RES_W-1:0] result_2;
	logic signed [SCL_W-1:0] scale_out;
	logic        [EXP_W-1:0] exponent_added;

	record_t  records_to_send [$];
	rescale_t pending_results [$];
	logic     neg_range = 1'b0;
	bit       beat_taken = 1'b0;
	int       idle_left = 0;
	int       gap_odds = 0;
	int       queued = 0;
	int       accepted = 0;
	int       errors = 0;
	record_t  drv_rec;
	rescale_t want_r;

	decimal_rescale_to_int16_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.value_0        (value_0),
		.value_1        (value_1),
		.value_2        (value_2),
		.lane_count     (lane_count),
		.scale_in       (scale_in),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.result_0       (result_0),
		.result_1       (result_1),
		.result_2       (result_2),
		.scale_out      (scale_out),
		.exponent_added (exponent_added)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic rescale_t rescale_of(input logic [VAL_W-1:0] s0, input logic [VAL_W-1:0] s1,
			input logic [VAL_W-1:0] s2, input logic [CNT_W-1:0] cnt,
			input logic [SCL_W-1:0] scl, input logic use_neg);
		logic [VAL_W-1:0] raw [LANES];
		logic [VAL_W-1:0] mag [LANES];
		logic             sgn [LANES];
		logic [VAL_W-1:0] res [LANES];
		logic [VAL_W-1:0] peak;
		logic [VAL_W-1:0] lim;
		logic [VAL_W-1:0] div;
		logic [VAL_W-1:0] q;
		logic             pos_peak;
		expo_t            ex;
		int               n;
		int               i;
		int               j;
		rescale_t         o;
		raw[0] = s0;
		raw[1] = s1;
		raw[2] = s2;
		n = (int'(cnt) > LANES) ? LANES : int'(cnt);
		peak = '0;
		pos_peak = 1'b0;
		for (i = 0; i < LANES; i++) begin
			sgn[i] = raw[i][VAL_W-1];
			mag[i] = sgn[i] ? (32'd0 - raw[i]) : raw[i];
			if (i < n) begin
				if (mag[i] > peak) begin
					peak = mag[i];
					pos_peak = !sgn[i];
				end else if (mag[i] == peak && !sgn[i]) begin
					pos_peak = 1'b1;
				end
			end
		end
		// a positive sample at the peak forces the positive table
		ex = EXP_NONE;
		div = '0;
		for (j = 0; j < STEPS; j++) begin
			lim = (use_neg && !pos_peak) ? NEG_LIMIT[j] : POS_LIMIT[j];
			if (ex == EXP_NONE && peak > lim) begin
				ex = expo_t'(STEPS - j);
				div = DIVISOR[j];
			end
		end
		for (i = 0; i < LANES; i++) begin
			if (i >= n) begin
				res[i] = '0;
			end else if (div == 0) begin
				res[i] = raw[i];
			end else begin
				q = (mag[i] + (div >> 1)) / div;
				res[i] = sgn[i] ? (32'd0 - q) : q;
			end
		end
		o.res0 = res[0][RES_W-1:0];
		o.res1 = res[1][RES_W-1:0];
		o.res2 = res[2][RES_W-1:0];
		o.scl = scl + {{(SCL_W-EXP_W){1'b0}}, ex};
		o.ex = ex;
		return o;
	endfunction

	// driver: next record on the falling edge once the previous beat has gone, with random idle gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || beat_taken) begin
			if (idle_left > 0) begin
				idle_left = idle_left - 1;
				start <= 1'b0;
				value_0 <= $urandom;
				lane_count <= $urandom_range(0, 3);
			end else if (records_to_send.size() != 0) begin
				drv_rec = records_to_send.pop_front();
				value_0 <= drv_rec.v0;
				value_1 <= drv_rec.v1;
				value_2 <= drv_rec.v2;
				lane_count <= drv_rec.cnt;
				scale_in <= drv_rec.scl;
				start <= 1'b1;
				if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
					idle_left = $urandom_range(1, 17);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results and predict on every accepted beat
	always @(posedge clk) begin
		if (!arst_n) begin
			beat_taken = 1'b0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result with no record outstanding");
					errors++;
				end else begin
					want_r = pending_results.pop_front();
					if (result_0 !== want_r.res0) begin
						$error("result_0: expected %0d, got %0d", want_r.res0, result_0);
						errors++;
					end
					if (result_1 !== want_r.res1) begin
						$error("result_1: expected %0d, got %0d", want_r.res1, result_1);
						errors++;
					end
					if (result_2 !== want_r.res2) begin
						$error("result_2: expected %0d, got %0d", want_r.res2, result_2);
						errors++;
					end
					if (scale_out !== want_r.scl) begin
						$error("scale_out: expected %0d, got %0d", want_r.scl, scale_out);
						errors++;
					end
					if (exponent_added !== want_r.ex) begin
						$error("exponent_added: expected %0d, got %0d", want_r.ex,
							exponent_added);
						errors++;
					end
				end
			end
			beat_taken = start && !busy;
			if (beat_taken) begin
				pending_results.push_back(rescale_of(value_0, value_1, value_2, lane_count,
					scale_in, neg_range));
				accepted++;
			end
		end
	end

	task automatic add_rec(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
			input logic [VAL_W-1:0] c, input int cnt, input int scl);
		record_t r;
		r.v0 = a;
		r.v1 = b;
		r.v2 = c;
		r.cnt = cnt[CNT_W-1:0];
		r.scl = scl[SCL_W-1:0];
		records_to_send.push_back(r);
		queued++;
	endtask

	task automatic wait_drain();
		while (accepted != queued || pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_range(input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		neg_range = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data <= 1'b0;
	endtask

	task automatic add_directed();
		add_rec(0, 0, 0, 3, 0);
		add_rec(32'sd2147483647, -32'sd2147483647, 5, 0, 17);
		add_rec(32'sd32767, -32'sd32768, 32'sd12, 3, -3);
		add_rec(-32'sd32768, 0, 0, 1, 4);
		add_rec(32'sd32768, 0, 0, 1, 4);
		// opposite signs at the same magnitude, both orders
		add_rec(-32'sd32768, 32'sd32768, 1, 2, 0);
		add_rec(32'sd32768, -32'sd32768, 1, 2, 0);
		add_rec(-32'sd32769, 32'sd100, -32'sd5, 3, 1);
		add_rec(32'sd327674, -32'sd327684, 0, 3, 2);
		add_rec(32'sd327675, 32'sd15, -32'sd15, 3, 2);
		add_rec(-32'sd327685, 32'sd44, -32'sd45, 3, 2);
		add_rec(32'sd3276749, -32'sd3276849, 0, 3, -10);
		add_rec(32'sd3276750, -32'sd3276850, 32'sd500, 3, -10);
		add_rec(32'sd32767499, -32'sd32768499, 0, 3, 60);
		add_rec(32'sd32767500, -32'sd32768500, -32'sd4999, 3, 60);
		add_rec(32'sd327674999, -32'sd327684999, 0, 3, -128);
		add_rec(32'sd327675000, -32'sd327685000, 32'sd50000, 3, -128);
		add_rec(32'sd2147483647, -32'sd2147483647, -32'sd49999, 3, 127);
		// rounding halves away from zero
		add_rec(32'sd32775, -32'sd32775, 32'sd32765, 3, 126);
		add_rec(-32'sd2147483647, 32'sd7, 32'sd2147483647, 2, -1);
		add_rec(32'sd1, -32'sd1, -32'sd2147483647, 2, 127);
		add_rec(-32'sd32768, -32'sd32768, -32'sd32768, 3, 5);
	endtask

	function automatic logic [VAL_W-1:0] pick_sample();
		logic [VAL_W-1:0] v;
		int               j;
		int               m;
		j = $urandom_range(0, STEPS - 1);
		case ($urandom_range(0, 7))
			0, 1: v = $urandom;
			2: begin
				m = (($urandom_range(0, 1) != 0) ? int'(NEG_LIMIT[j]) : int'(POS_LIMIT[j]))
					+ int'($urandom_range(0, 4)) - 2;
				v = m;
			end
			3: v = {{16{1'b0}}, 16'($urandom)};
			4: v = '0;
			5: v = 32'd32767 + $urandom_range(0, 2);
			default: v = $urandom >> $urandom_range(0, 31);
		endcase
		if ($urandom_range(0, 1) != 0)
			v = 32'd0 - v;
		// the most negative sample is outside the input range
		if (v == 32'h8000_0000)
			v = 32'h8000_0001;
		return v;
	endfunction

	task automatic add_random(input int count);
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
		logic [VAL_W-1:0] c;
		int               cnt;
		int               k;
		for (k = 0; k < count; k++) begin
			a = pick_sample();
			b = pick_sample();
			c = pick_sample();
			if ($urandom_range(0, 7) == 0)
				b = 32'd0 - a;
			cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3;
			add_rec(a, b, c, cnt, $urandom_range(0, 255));
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// register still at its reset value
		gap_odds = 4;
		add_directed();
		wait_drain();
		write_range(1'b1);
		gap_odds = 3;
		add_directed();
		wait_drain();

		write_range(1'b0);
		gap_odds = 6;
		add_random(90);
		wait_drain();
		write_range(1'b1);
		gap_odds = 2;
		add_random(90);
		wait_drain();
		write_range(1'b0);
		gap_odds = 0;
		add_random(90);
		wait_drain();
		write_range(1'b1);
		gap_odds = 5;
		add_random(90);
		wait_drain();
		write_range($urandom_range(0, 1));
		gap_odds = 0;
		add_random(90);
		wait_drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
